/* hdl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the PLL divider search block.
// ----------------------------------------------------------------------------
package pds_pkg;

	// configuration register widths and reset values
	localparam int REF_W = 26;
	localparam int MAX_W = 29;
	localparam int TGT_W = 32;
	localparam int NUM_W = 7;
	localparam int PSL_W = 2;
	localparam int ACH_W = 30;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	localparam logic [REF_W-1:0] REF_RESET = REF_W'(14318000);
	localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(175000000);

	// post-scaler thresholds
	localparam logic [MAX_W-1:0] TH_PS1 = MAX_W'(75000000);
	localparam logic [MAX_W-1:0] TH_PS2 = MAX_W'(37500000);
	localparam logic [MAX_W-1:0] TH_PS4 = MAX_W'(13500000);

	localparam logic [PSL_W-1:0] PSL_DIV1 = 2'd0;
	localparam logic [PSL_W-1:0] PSL_DIV2 = 2'd1;
	localparam logic [PSL_W-1:0] PSL_DIV4 = 2'd2;
	localparam logic [PSL_W-1:0] PSL_DIV8 = 2'd3;

	// register indexes
	localparam logic REG_REF = 1'b0;
	localparam logic REG_MAX = 1'b1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SETUP = 8'b0000_0010,
		S_INIT  = 8'b0000_0100,
		S_SWEEP = 8'b0000_1000,
		S_DRAIN = 8'b0001_0000,
		S_MUL   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic capture;
		logic setup;
		logic init;
		logic sweep;
		logic mul;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
	} stat_t;

endpackage

/* hdl/pds_ifs.sv */
// ----------------------------------------------------------------------------
// pds_req_if / pds_rsp_if
// Valid/ready channels for requests and results of the divider search.
// ----------------------------------------------------------------------------
interface pds_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] target_hz;

	modport source (output valid, output target_hz, input ready);
	modport sink (input valid, input target_hz, output ready);
endinterface

interface pds_rsp_if;
	logic        valid;
	logic        ready;
	logic [6:0]  numerator;
	logic [6:0]  denominator;
	logic [1:0]  postscale_log2;
	logic [29:0] achieved_hz;

	modport source (output valid, output numerator, output denominator,
		output postscale_log2, output achieved_hz, input ready);
	modport sink (input valid, input numerator, input denominator,
		input postscale_log2, input achieved_hz, output ready);
endinterface

/* hdl/pll_divider_search.sv */
// ----------------------------------------------------------------------------
// pll_divider_search
// Exhaustive PLL numerator/denominator search for a requested pixel clock.
// ----------------------------------------------------------------------------
// usage
//   target: request channel (valid/ready), one requested clock in Hz
//   result: result channel (valid/ready), numerator, denominator,
//           post-scaler log2 and achieved clock
//   apb:    ref_clock_hz at 0x0, max_clock_hz at 0x4; write only while idle
// timing
//   one request at a time; the candidate sweep tests one
//   numerator/denominator pair per cycle, then a bit-serial divide
//   gives the achieved clock
//   a new request is taken as soon as the previous one is in the result
//   register, even if the receiver has not taken it yet
// reset
//   arst_n clears the sequencer and the result valid; registers return
//   to 14.318 MHz reference and 175 MHz maximum
// stall
//   a stalled result holds; a finished search waits until the result
//   register frees up
// ----------------------------------------------------------------------------
module pll_divider_search
	import pds_pkg::*;
#(
	parameter int RATIO_MIN   = 2,
	parameter int RATIO_LIMIT = 126
) (
	input  logic              clk,
	input  logic              arst_n,
	pds_req_if.sink           target,
	pds_rsp_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// configuration values
	logic [REF_W-1:0] ref_clock_hz;
	logic [MAX_W-1:0] max_clock_hz;

	// controller <-> datapath
	cmd_t  cmd;
	stat_t stat;

	pds_apb u_apb (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.ref_clock_hz (ref_clock_hz),
		.max_clock_hz (max_clock_hz)
	);

	// sequencer: owns request ready and result valid
	pds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (target.valid),
		.in_ready  (target.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: sweep, compare, divide and result register
	pds_dp #(
		.RATIO_MIN   (RATIO_MIN),
		.RATIO_LIMIT (RATIO_LIMIT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.target_hz      (target.target_hz),
		.ref_clock_hz   (ref_clock_hz),
		.max_clock_hz   (max_clock_hz),
		.numerator      (result.numerator),
		.denominator    (result.denominator),
		.postscale_log2 (result.postscale_log2),
		.achieved_hz    (result.achieved_hz)
	);

endmodule

/* hdl/pds_apb.sv */
// ----------------------------------------------------------------------------
// pds_apb
// APB register file: reference clock and maximum clock.
// ----------------------------------------------------------------------------
module pds_apb
	import pds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [REF_W-1:0]  ref_clock_hz,
	output logic [MAX_W-1:0]  max_clock_hz
);

	logic [REF_W-1:0] ref_q;
	logic [MAX_W-1:0] max_q;
	logic             wr_en;
	logic             idx;

	assign pready = 1'b1;
	assign idx    = paddr[2];
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
			max_q <= MAX_RESET;
		end else if (wr_en) begin
			if (idx == REG_REF) begin
				ref_q <= pwdata[REF_W-1:0];
			end else begin
				max_q <= pwdata[MAX_W-1:0];
			end
		end
	end

	always_comb begin
		if (idx == REG_REF) begin
			prdata = APB_DW'(ref_q);
		end else begin
			prdata = APB_DW'(max_q);
		end
	end

	assign ref_clock_hz = ref_q;
	assign max_clock_hz = max_q;

endmodule

/* hdl/pds_ctrl.sv */
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer: setup, candidate sweep, divide and result hand-off.
// ----------------------------------------------------------------------------
module pds_ctrl
	import pds_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nxt = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_nxt = S_INIT;
			end
			S_INIT: begin
				cmd.init  = 1'b1;
				state_nxt = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_MUL;
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/pds_dp.sv */
// ----------------------------------------------------------------------------
// pds_dp
// Datapath: clamp and scaler, ratio sweep with exact error compare,
// bit-serial divide for the achieved clock, result register.
// ----------------------------------------------------------------------------
module pds_dp
	import pds_pkg::*;
#(
	parameter int RATIO_MIN   = 2,
	parameter int RATIO_LIMIT = 126
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [TGT_W-1:0]  target_hz,
	input  logic [REF_W-1:0]  ref_clock_hz,
	input  logic [MAX_W-1:0]  max_clock_hz,
	output logic [NUM_W-1:0]  numerator,
	output logic [NUM_W-1:0]  denominator,
	output logic [PSL_W-1:0]  postscale_log2,
	output logic [ACH_W-1:0]  achieved_hz
);

	localparam int CW  = $clog2(RATIO_LIMIT);
	localparam int DW  = MAX_W;
	localparam int EW  = DW + CW;
	localparam int PW  = EW + CW;
	localparam int QW  = REF_W + CW;
	localparam int QCW = $clog2(QW);
	localparam logic [CW-1:0]  R_FIRST = CW'(RATIO_MIN);
	localparam logic [CW-1:0]  R_LAST  = CW'(RATIO_LIMIT - 1);
	localparam logic [QCW-1:0] DIV_LAST = QCW'(QW - 1);
	localparam logic [QW-1:0]  ACH_SAT = QW'({ACH_W{1'b1}});

	// request setup
	logic [MAX_W-1:0] clk_q;
	logic [DW-1:0]    desired_q;
	logic [PSL_W-1:0] pslog_q;
	logic [PSL_W-1:0] pslog_c;

	// sweep counters and running products
	logic [CW-1:0] n_q, d_q;
	logic [EW-1:0] dacc_q, dbase_q, nacc_q;

	// stage 1: error of current pair
	logic          v_s1;
	logic [EW-1:0] e_s1;
	logic [CW-1:0] n_s1, d_s1;

	// stage 2: best pair
	logic          have_q;
	logic [EW-1:0] best_e_q;
	logic [CW-1:0] best_n_q, best_d_q;
	logic [PW-1:0] prod_new, prod_best;
	logic          take;

	// divider
	logic [QW-1:0]  quo_q;
	logic [CW-1:0]  rem_q;
	logic [QCW-1:0] dcnt_q;
	logic [CW:0]    rem_sh, rem_sub;
	logic           rem_ge;
	logic [QW-1:0]  q_sh;

	logic [CW+NUM_W-1:0] n_wide, d_wide;

	always_comb begin
		if (clk_q >= TH_PS1) begin
			pslog_c = PSL_DIV1;
		end else if (clk_q >= TH_PS2) begin
			pslog_c = PSL_DIV2;
		end else if (clk_q >= TH_PS4) begin
			pslog_c = PSL_DIV4;
		end else begin
			pslog_c = PSL_DIV8;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (target_hz > TGT_W'(max_clock_hz)) begin
				clk_q <= max_clock_hz;
			end else begin
				clk_q <= target_hz[MAX_W-1:0];
			end
		end
		if (cmd.setup) begin
			pslog_q   <= pslog_c;
			desired_q <= clk_q << pslog_c;
		end
	end

	// running products: desired*d and ref*n
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			n_q     <= R_FIRST;
			d_q     <= R_FIRST;
			dbase_q <= EW'(desired_q) * EW'(R_FIRST);
			dacc_q  <= EW'(desired_q) * EW'(R_FIRST);
			nacc_q  <= EW'(ref_clock_hz) * EW'(R_FIRST);
		end else if (cmd.sweep) begin
			if (d_q == R_LAST) begin
				d_q    <= R_FIRST;
				dacc_q <= dbase_q;
				n_q    <= n_q + 1'b1;
				nacc_q <= nacc_q + EW'(ref_clock_hz);
			end else begin
				d_q    <= d_q + 1'b1;
				dacc_q <= dacc_q + EW'(desired_q);
			end
		end
	end

	assign stat.last = (n_q == R_LAST) && (d_q == R_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			e_s1 <= (dacc_q >= nacc_q) ? dacc_q - nacc_q : nacc_q - dacc_q;
			n_s1 <= n_q;
			d_s1 <= d_q;
		end
	end

	// compare e/d against best_e/best_d without division
	assign prod_new  = PW'(e_s1) * PW'(best_d_q);
	assign prod_best = PW'(best_e_q) * PW'(d_s1);
	assign take      = !have_q || (prod_new < prod_best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.init) begin
			have_q <= 1'b0;
		end else if (v_s1) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && take) begin
			best_e_q <= e_s1;
			best_n_q <= n_s1;
			best_d_q <= d_s1;
		end
	end

	// restoring divide of ref*n by d, one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[QW-1]};
	assign rem_ge  = rem_sh >= {1'b0, best_d_q};
	assign rem_sub = rem_sh - {1'b0, best_d_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q  <= QW'(ref_clock_hz) * QW'(best_n_q);
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[QW-2:0], rem_ge};
			rem_q  <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	assign stat.div_done = (dcnt_q == DIV_LAST);

	// post-scaler is a power of two, so it is a shift after the divide
	assign q_sh   = quo_q >> pslog_q;
	assign n_wide = (CW+NUM_W)'(best_n_q);
	assign d_wide = (CW+NUM_W)'(best_d_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			numerator      <= n_wide[NUM_W-1:0];
			denominator    <= d_wide[NUM_W-1:0];
			postscale_log2 <= pslog_q;
			achieved_hz    <= (q_sh > ACH_SAT) ? {ACH_W{1'b1}} : q_sh[ACH_W-1:0];
		end
	end

endmodule

/* tb/tb_pll_divider_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pll_divider_search
// Self-checking bench for the PLL divider search. Requested clocks are fed
// through the request channel under several reference/maximum settings and
// each result is compared against an exhaustive search done in the bench.
// ----------------------------------------------------------------------------
module tb_pll_divider_search;
	import pds_pkg::*;

	localparam int RATIO_MIN   = 2;
	localparam int RATIO_LIMIT = 126;
	// watchdog limit, with plenty of margin over the slowest clean run
	localparam int unsigned CYCLE_LIMIT = 6_500_000;
	// long enough for two full searches, so the block backs up into its input
	localparam int unsigned LONG_HOLD = 40_000;
	localparam int unsigned TAIL_CYCLES = 200;

	typedef struct packed {
		logic [NUM_W-1:0] numerator;
		logic [NUM_W-1:0] denominator;
		logic [PSL_W-1:0] postscale_log2;
		logic [ACH_W-1:0] achieved_hz;
	} pll_setting_t;

	// clock, reset and bench-side copies of what is driven into the block
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic [TGT_W-1:0]  req_target = '0;
	logic              rsp_ready = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	pds_req_if req_ch ();
	pds_rsp_if rsp_ch ();

	assign req_ch.valid     = req_valid;
	assign req_ch.target_hz = req_target;
	assign rsp_ch.ready     = rsp_ready;

	pll_divider_search #(
		.RATIO_MIN   (RATIO_MIN),
		.RATIO_LIMIT (RATIO_LIMIT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.target  (req_ch.sink),
		.result  (rsp_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// bench copy of the two registers, changed only while the block is idle
	logic [REF_W-1:0] ref_shadow = REF_RESET;
	logic [MAX_W-1:0] max_shadow = MAX_RESET;

	logic [TGT_W-1:0] queued_targets[$];
	pll_setting_t     awaited_settings[$];

	bit          src_idling = 1'b1;
	bit          snk_idling = 1'b1;
	int unsigned src_gap = 0;
	int unsigned snk_gap = 0;
	int unsigned hold_cnt = 0;
	bit          hold_done = 1'b0;
	int unsigned results_seen = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	pll_setting_t got_setting;
	pll_setting_t want_setting;

	logic [TGT_W-1:0] corner_targets[16] = '{
		32'd0, 32'd1, 32'd13499999, 32'd13500000,
		32'd37499999, 32'd37500000, 32'd74999999, 32'd75000000,
		32'd174999999, 32'd175000000, 32'd175000001, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h7FFF_FFFF, 32'd25175000, 32'd65000000
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// exhaustive search for the best numerator/denominator pair
	function automatic pll_setting_t search_divider(input logic [TGT_W-1:0] target,
			input logic [REF_W-1:0] refc, input logic [MAX_W-1:0] maxc);
		logic [63:0]      clamped, desired, ref64, n, d;
		logic [63:0]      err, best_err, best_n, best_d, span, ach;
		logic [PSL_W-1:0] psl;
		bit               found;
		pll_setting_t     res;
		clamped = 64'(target);
		if (clamped > 64'(maxc))
			clamped = 64'(maxc);
		// post-scaler from fixed thresholds
		if (clamped >= 64'(TH_PS1))
			psl = PSL_DIV1;
		else if (clamped >= 64'(TH_PS2))
			psl = PSL_DIV2;
		else if (clamped >= 64'(TH_PS4))
			psl = PSL_DIV4;
		else
			psl = PSL_DIV8;
		desired = clamped << psl;
		ref64 = 64'(refc);
		found = 1'b0;
		best_n = '0;
		best_d = '0;
		best_err = '0;
		// numerator outermost, strictly better replaces, so ties keep the first
		for (n = 64'(RATIO_MIN); n < 64'(RATIO_LIMIT); n++) begin
			for (d = 64'(RATIO_MIN); d < 64'(RATIO_LIMIT); d++) begin
				if (desired * d >= ref64 * n)
					err = desired * d - ref64 * n;
				else
					err = ref64 * n - desired * d;
				// errors are err/d, compared by cross-multiplying
				if (!found || err * best_d < best_err * d) begin
					found = 1'b1;
					best_n = n;
					best_d = d;
					best_err = err;
				end
			end
		end
		span = best_d << psl;
		if (!found || span == '0)
			ach = '0;
		else
			ach = (ref64 * best_n) / span;
		if (ach > 64'({ACH_W{1'b1}}))
			ach = 64'({ACH_W{1'b1}});
		res.numerator      = best_n[NUM_W-1:0];
		res.denominator    = best_d[NUM_W-1:0];
		res.postscale_log2 = psl;
		res.achieved_hz    = ach[ACH_W-1:0];
		return res;
	endfunction

	// random request: full range, in range, around a threshold or the clamp,
	// or up to TH_PS4, or between TH_PS4 and TH_PS1
	function automatic logic [TGT_W-1:0] pick_target(input logic [MAX_W-1:0] limit);
		logic [TGT_W-1:0] marks[4];
		marks = '{TGT_W'(TH_PS1), TGT_W'(TH_PS2), TGT_W'(TH_PS4), TGT_W'(limit)};
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, limit);
			2: return marks[$urandom_range(0, 3)] + TGT_W'($urandom_range(0, 8)) - 32'd4;
			3: return $urandom_range(0, TH_PS4);
			default: return $urandom_range(TH_PS4, TH_PS1);
		endcase
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// apb write, then read back and compare with the masked value
	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] want;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_REF)
			ref_shadow = value[REF_W-1:0];
		else
			max_shadow = value[MAX_W-1:0];
		want = (idx == REG_REF) ? APB_DW'(ref_shadow) : APB_DW'(max_shadow);
		@(posedge clk);
		psel  <= 1'b1;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (prdata !== want)
			note_error($sformatf("register %0d readback: expected %0d, got %0d",
				idx, want, prdata));
	endtask

	// block is idle once nothing is queued, offered or awaited
	task automatic wait_drained();
		do @(posedge clk);
		while (queued_targets.size() != 0 || req_valid || awaited_settings.size() != 0);
	endtask

	task automatic run_phase(input logic [APB_DW-1:0] refv, input logic [APB_DW-1:0] maxv,
			input int count, input bit src_idle, input bit snk_idle);
		write_reg(REG_REF, refv);
		write_reg(REG_MAX, maxv);
		src_idling = src_idle;
		snk_idling = snk_idle;
		repeat (count)
			queued_targets.push_back(pick_target(max_shadow));
		wait_drained();
	endtask

	// request driver, predicts each request as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			req_target <= '0;
			src_gap    <= 0;
		end else begin
			if (req_valid && req_ch.ready)
				awaited_settings.push_back(search_divider(req_target, ref_shadow, max_shadow));
			if (!req_valid || req_ch.ready) begin
				if (src_gap != 0) begin
					src_gap   <= src_gap - 1;
					req_valid <= 1'b0;
				end else if (queued_targets.size() == 0) begin
					req_valid <= 1'b0;
				end else if (src_idling && $urandom_range(0, 3) == 0) begin
					// idle burst of random length
					src_gap   <= $urandom_range(0, 15);
					req_valid <= 1'b0;
				end else begin
					req_valid  <= 1'b1;
					req_target <= queued_targets.pop_front();
				end
			end
		end
	end

	// one long receiver hold-off early on, while the sender keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen == 2) begin
			hold_cnt  <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// result ready with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			snk_gap   <= 0;
		end else if (hold_cnt != 0) begin
			rsp_ready <= 1'b0;
		end else if (snk_gap != 0) begin
			snk_gap   <= snk_gap - 1;
			rsp_ready <= 1'b0;
		end else if (snk_idling && $urandom_range(0, 5) == 0) begin
			snk_gap   <= $urandom_range(0, 15);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// result monitor, compares against the oldest awaited setting
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ready) begin
			results_seen <= results_seen + 1;
			got_setting.numerator      = rsp_ch.numerator;
			got_setting.denominator    = rsp_ch.denominator;
			got_setting.postscale_log2 = rsp_ch.postscale_log2;
			got_setting.achieved_hz    = rsp_ch.achieved_hz;
			if (awaited_settings.size() == 0) begin
				note_error($sformatf("result with nothing awaited: n=%0d d=%0d ps=%0d ach=%0d",
					got_setting.numerator, got_setting.denominator,
					got_setting.postscale_log2, got_setting.achieved_hz));
			end else begin
				want_setting = awaited_settings.pop_front();
				if (got_setting.numerator !== want_setting.numerator
						|| got_setting.denominator !== want_setting.denominator
						|| got_setting.postscale_log2 !== want_setting.postscale_log2
						|| got_setting.achieved_hz !== want_setting.achieved_hz)
					note_error($sformatf({"result mismatch: expected n=%0d d=%0d ps=%0d ach=%0d,",
						" got n=%0d d=%0d ps=%0d ach=%0d"},
						want_setting.numerator, want_setting.denominator,
						want_setting.postscale_log2, want_setting.achieved_hz,
						got_setting.numerator, got_setting.denominator,
						got_setting.postscale_log2, got_setting.achieved_hz));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_pll_divider_search: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// corners at the reset settings: zero, thresholds and their neighbors,
		// the clamp, the top of the request range
		src_idling = 1'b1;
		snk_idling = 1'b1;
		foreach (corner_targets[i])
			queued_targets.push_back(corner_targets[i]);
		wait_drained();

		// lowest reference and clamp
		run_phase(32'd1000000, 32'd1000000, 10, 1'b1, 1'b1);
		// highest reference and clamp
		run_phase(32'd50000000, 32'd400000000, 10, 1'b1, 1'b1);
		// zero reference, every pair ties so the first one wins
		run_phase(32'd0, 32'd175000000, 6, 1'b0, 1'b1);
		// all-ones writes, only the register widths survive
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8, 1'b1, 1'b0);
		// a few random settings inside the usual ranges
		run_phase($urandom_range(1000000, 50000000), $urandom_range(1000000, 400000000),
			10, 1'b1, 1'b1);
		run_phase($urandom_range(1000000, 50000000), $urandom_range(1000000, 400000000),
			10, 1'b0, 1'b1);
		run_phase($urandom_range(1000000, 50000000), $urandom_range(1000000, 400000000),
			10, 1'b1, 1'b0);
		// back to reset values, back-to-back with no idling
		run_phase(32'd14318000, 32'd175000000, 20, 1'b0, 1'b0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_pll_divider_search: done, clean");
		else
			$display("tb_pll_divider_search: done, errors");
		$finish;
	end

endmodule
